[hw/rtl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division primality tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_W = 32;
  localparam int EXT_W  = 64;

  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

[hw/rtl/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Trial-division primality test: a sequencer walks divisors 2, 3, ... while
// divisor squared stays at most the candidate, using a bit-serial remainder
// unit for each trial.
//
//   channel   ports                          handshake
//   input     in_candidate[31:0]             start && !busy
//   result    out_is_prime                   out_valid, one cycle
//
// Candidates 0 and 1 answer in the cycle after acceptance. Otherwise each
// divisor takes one bound check, DATA_WIDTH remainder steps in the serial
// remainder unit and one evaluation; the worst case is about
// 2**(DATA_WIDTH/2) divisors. busy stays high for the whole test.
// Reset returns the block to idle with no result pending. The receiver
// cannot stall: the strobe lasts one cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tdpt_pkg::CAND_W-1:0] in_candidate,
  output logic                        out_valid,
  output logic                        out_is_prime
);
  import tdpt_pkg::*;

  localparam int DIV_W = (DATA_WIDTH + 1) / 2 + 1;
  localparam int SQ_W  = 2 * DIV_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [DATA_WIDTH-1:0] held_r;
  logic [DIV_W-1:0]      div_r;
  logic [SQ_W-1:0]       sq_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_is_prime_r;
  logic                  out_is_prime_nxt;
  logic [EXT_W-1:0]      cand_ext;
  logic [DATA_WIDTH-1:0] cand_w;
  logic                  cand_small;
  logic                  bound_hit;
  rem_ctrl_t             rem_ctrl;
  rem_stat_t             rem_stat;

  assign cand_ext   = {{(EXT_W - CAND_W){1'b0}}, in_candidate};
  assign cand_w     = cand_ext[DATA_WIDTH-1:0];
  assign cand_small = (cand_w[DATA_WIDTH-1:1] == '0);
  assign bound_hit  = (sq_r > SQ_W'(held_r));

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    rem_ctrl.start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cand_small) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (bound_hit) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          rem_ctrl.start = 1'b1;
          state_nxt      = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
            state_nxt        = ST_IDLE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // advance divisor and its square: (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    out_is_prime_r <= out_is_prime_nxt;
    if (state_r == ST_IDLE && start) begin
      held_r <= cand_w;
      div_r  <= DIV_W'(2);
      sq_r   <= SQ_W'(4);
    end else if (state_r == ST_WAIT && rem_stat.done) begin
      div_r <= div_r + 1'b1;
      sq_r  <= sq_r + SQ_W'({div_r, 1'b1});
    end
  end

  tdpt_rem_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .DIV_W     (DIV_W)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rem_ctrl),
    .dividend(held_r),
    .divisor (div_r),
    .stat    (rem_stat)
  );

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

[hw/rtl/tdpt_rem_unit.sv]
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle through a single
// subtractor; reports done and a zero remainder flag.
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int DIV_W      = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdpt_pkg::rem_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DIV_W-1:0]      divisor,
  output tdpt_pkg::rem_stat_t   stat
);
  import tdpt_pkg::*;

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic [DATA_WIDTH-1:0] shift_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      rem_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;

  assign trial = {rem_r, shift_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    if (diff[DIV_W]) begin
      rem_nxt = trial[DIV_W-1:0];
    end else begin
      rem_nxt = diff[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      shift_r <= dividend;
      rem_r   <= '0;
      cnt_r   <= CNT_W'(DATA_WIDTH - 1);
    end else if (run_r) begin
      shift_r <= {shift_r[DATA_WIDTH-2:0], 1'b0};
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

[hw/rtl/tdpt_checker.sv]
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks for the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [tdpt_pkg::CAND_W-1:0] in_candidate,
  input logic                        out_valid,
  input logic                        out_is_prime
);
  import tdpt_pkg::*;

  logic [EXT_W-1:0]      cand_ext;
  logic [DATA_WIDTH-1:0] cand_w;
  logic                  cand_small;

  assign cand_ext   = {{(EXT_W - CAND_W){1'b0}}, in_candidate};
  assign cand_w     = cand_ext[DATA_WIDTH-1:0];
  assign cand_small = (cand_w[DATA_WIDTH-1:1] == '0);

  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && cand_small |=> out_valid && !out_is_prime && !busy)
    else $error("zero or one not answered as not prime");

  a_large_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cand_small |=> busy && !out_valid)
    else $error("test did not start");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("test ended without result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind trial_division_prime_test tdpt_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_tdpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_candidate(in_candidate),
  .out_valid   (out_valid),
  .out_is_prime(out_is_prime)
);
